>>> sv/ifp_pkg.sv
// ============================================================================
// ifp_pkg
// Shared types and constants for the imu serial frame parser.
// ============================================================================
package ifp_pkg;

    // frame layout
    localparam int PAYLOAD_BYTES = 13;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(PAYLOAD_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_YAW_LOW  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_YAW_HIGH = IDX_W'(2);

    // sync pair
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h00;

    // heading offset, 180 degrees in hundredths
    localparam logic signed [16:0] HEADING_OFFSET = 17'sd18000;

    // configuration register map
    localparam int             ADDR_W        = 3;
    localparam logic           REG_THRESHOLD = 1'b0;
    localparam logic [4:0]     THRESHOLD_RST = 5'd20;

    // frame phase, one-hot
    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_CONFIRM = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    // end-of-frame report from the framing core
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [15:0] yaw;
    } frame_t;

endpackage

>>> sv/ifp_frame_core.sv
// ============================================================================
// ifp_frame_core
// Sync hunt, payload capture, additive checksum; one word a cycle on in_accept.
// ============================================================================
module ifp_frame_core
    import ifp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] rx_byte,
    output frame_t     frame,
    output logic       at_end
);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       low_reg, low_next;
    logic [7:0]       high_reg, high_next;

    // next word closes a frame whatever its value
    assign at_end = (phase_reg == PH_PAYLOAD) && (idx_reg == IDX_LAST);

    // framing state update
    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        frame.done  = 1'b0;
        frame.ok    = (sum_reg == rx_byte);
        frame.yaw   = {high_reg, low_reg};
        if (in_accept) begin
            unique case (phase_reg)
                PH_CONFIRM: begin
                    if (rx_byte == SYNC_SECOND) begin
                        phase_next = PH_PAYLOAD;
                        idx_next   = '0;
                        sum_next   = '0;
                        low_next   = '0;
                        high_next  = '0;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    if (idx_reg != IDX_LAST) begin
                        sum_next = sum_reg + rx_byte;
                        if (idx_reg == IDX_YAW_LOW) begin
                            low_next = rx_byte;
                        end else if (idx_reg == IDX_YAW_HIGH) begin
                            high_next = rx_byte;
                        end
                        idx_next = idx_reg + IDX_W'(1);
                    end else begin
                        frame.done = 1'b1;
                        phase_next = PH_HUNT;
                        idx_next   = '0;
                        sum_next   = '0;
                    end
                end
                default: begin
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_CONFIRM : PH_HUNT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            sum_reg   <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

endmodule

>>> sv/imu_serial_frame_parser.sv
// ============================================================================
// imu_serial_frame_parser
// Sync-header serial frame parser with additive checksum and heading output.
// ============================================================================
// result: registered on the m_ side in the cycle after the closing word
// throughput: one word per cycle; s_ready drops only while the closing word is
//   due and the previous result still sits unaccepted in the output register
// reset: aresetn synchronous active low; hunting, counters and yaw cleared,
//   toggle_threshold back to 20
module imu_serial_frame_parser
    import ifp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_checksum_ok,
    output logic signed [15:0]       m_yaw_raw,
    output logic signed [16:0]       m_yaw_centi_deg,
    output logic                     m_indicator_led,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic              in_accept;
    logic              at_end;
    frame_t            frame;

    logic [4:0]        threshold_reg, threshold_next;
    logic [15:0]       yaw_reg, yaw_next;
    logic [4:0]        count_reg, count_next;
    logic              led_reg, led_next;

    logic              m_valid_reg, m_valid_next;
    logic              ok_reg;
    logic [15:0]       out_yaw_reg;
    logic [16:0]       heading_reg;
    logic              out_led_reg;

    // handshake
    assign s_ready   = !(at_end && m_valid_reg && !m_ready);
    assign in_accept = s_valid && s_ready;

    ifp_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .rx_byte   (s_rx_byte),
        .frame     (frame),
        .at_end    (at_end)
    );

    // configuration writes and reads
    assign pready = 1'b1;

    always_comb begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) begin
            threshold_next = pwdata[4:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_THRESHOLD) begin
            prdata = {27'd0, threshold_reg};
        end
    end

    // held yaw, good-frame counter and indicator
    always_comb begin
        yaw_next   = yaw_reg;
        count_next = count_reg;
        led_next   = led_reg;
        if (frame.done && frame.ok) begin
            yaw_next = frame.yaw;
            if (count_reg >= threshold_reg) begin
                led_next   = !led_reg;
                count_next = '0;
            end else begin
                count_next = count_reg + 5'd1;
            end
        end
    end

    // output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (frame.done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            yaw_reg       <= '0;
            count_reg     <= '0;
            led_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            threshold_reg <= threshold_next;
            yaw_reg       <= yaw_next;
            count_reg     <= count_next;
            led_reg       <= led_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (frame.done) begin
            ok_reg      <= frame.ok;
            out_yaw_reg <= yaw_next;
            heading_reg <= $signed({yaw_next[15], yaw_next}) + HEADING_OFFSET;
            out_led_reg <= led_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_checksum_ok   = ok_reg;
    assign m_yaw_raw       = $signed(out_yaw_reg);
    assign m_yaw_centi_deg = $signed(heading_reg);
    assign m_indicator_led = out_led_reg;

endmodule

>>> test/tb_imu_serial_frame_parser.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_imu_serial_frame_parser
// Self-checking bench for the sync-header frame parser: a byte-level parser
// model predicts one report per closed payload, a monitor compares each
// report field by field, and the toggle threshold is swept between phases.
// ============================================================================
module tb_imu_serial_frame_parser;
    import ifp_pkg::*;

    localparam int CLK_HALF         = 1;
    localparam int RESET_CYCLES     = 6;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 190;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 4;
    localparam int CYCLE_LIMIT      = 400000;
    localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = ADDR_W'(4 * REG_THRESHOLD);
    localparam logic [ADDR_W-1:0] ADDR_SPARE     = ADDR_W'(4);
    // negative entry means pick a random threshold
    localparam int PHASE_THRESHOLD [PHASES] = '{20, 31, 2, 0, 31, 1, -1, 20};

    typedef struct {
        logic               ok;
        logic signed [15:0] yaw;
        logic signed [16:0] heading;
        logic               led;
    } frame_report_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_checksum_ok;
    logic signed [15:0] m_yaw_raw;
    logic signed [16:0] m_yaw_centi_deg;
    logic               m_indicator_led;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // parser model state
    phase_t       parse_phase = PH_HUNT;
    logic [3:0]   payload_pos = '0;
    logic [7:0]   payload_sum = '0;
    logic [7:0]   yaw_lo = '0;
    logic [7:0]   yaw_hi = '0;
    logic [15:0]  held_yaw = '0;
    logic [4:0]   good_count = '0;
    logic         led_state = 1'b0;
    logic [4:0]   threshold_model = THRESHOLD_RST;

    logic [7:0]    serial_bytes_pending [$];
    frame_report_t frame_reports_due [$];
    frame_report_t want;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  bytes_queued = 0;
    int  bytes_accepted = 0;
    int  reports_checked = 0;
    int  good_frames = 0;
    int  bad_frames = 0;
    int  led_toggles = 0;
    int  input_stall_cycles = 0;
    int  send_gap = 0;
    int  recv_hold = 0;
    bit  idling_on = 1'b1;
    bit  long_hold_req = 1'b0;

    imu_serial_frame_parser i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_checksum_ok   (m_checksum_ok),
        .m_yaw_raw       (m_yaw_raw),
        .m_yaw_centi_deg (m_yaw_centi_deg),
        .m_indicator_led (m_indicator_led),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports still due",
                     cycle_count, frame_reports_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("check failed at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // byte-level parser model, one call per accepted word
    function automatic void parse_rx_byte(input logic [7:0] b);
        frame_report_t r;
        case (parse_phase)
            PH_CONFIRM: begin
                if (b == SYNC_SECOND) begin
                    parse_phase = PH_PAYLOAD;
                    payload_pos = '0;
                    payload_sum = '0;
                    yaw_lo      = '0;
                    yaw_hi      = '0;
                end else begin
                    // rejected byte is not looked at again, even a sync byte
                    parse_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                if (payload_pos < PAYLOAD_BYTES - 1) begin
                    payload_sum = payload_sum + b;
                    if (payload_pos == 4'd1)
                        yaw_lo = b;
                    else if (payload_pos == 4'd2)
                        yaw_hi = b;
                    payload_pos = payload_pos + 4'd1;
                end else begin
                    r.ok = (payload_sum == b);
                    // bad frame keeps yaw, count and indicator as they are
                    if (r.ok) begin
                        good_frames++;
                        held_yaw = {yaw_hi, yaw_lo};
                        if (good_count >= threshold_model) begin
                            led_state  = ~led_state;
                            good_count = '0;
                            led_toggles++;
                        end else begin
                            good_count = good_count + 5'd1;
                        end
                    end else begin
                        bad_frames++;
                    end
                    r.yaw     = held_yaw;
                    r.heading = $signed({held_yaw[15], held_yaw}) + HEADING_OFFSET;
                    r.led     = led_state;
                    frame_reports_due.push_back(r);
                    parse_phase = PH_HUNT;
                    payload_pos = '0;
                    payload_sum = '0;
                end
            end
            default: begin
                parse_phase = (b == SYNC_FIRST) ? PH_CONFIRM : PH_HUNT;
            end
        endcase
    endfunction

    // input driver, fed from the pending byte queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_rx_byte(s_rx_byte);
                bytes_accepted++;
            end
            if (s_valid && !s_ready)
                input_stall_cycles++;
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (serial_bytes_pending.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 12);
                    s_valid <= 1'b0;
                end else begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= serial_bytes_pending.pop_front();
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_reports_due.size() == 0) begin
                    report_mismatch("report word with no closed payload pending");
                end else begin
                    want = frame_reports_due.pop_front();
                    reports_checked++;
                    if (m_checksum_ok !== want.ok)
                        report_mismatch($sformatf("checksum_ok expected %0d got %0d",
                                                  want.ok, m_checksum_ok));
                    if (m_yaw_raw !== want.yaw)
                        report_mismatch($sformatf("yaw_raw expected %0d got %0d",
                                                  want.yaw, m_yaw_raw));
                    if (m_yaw_centi_deg !== want.heading)
                        report_mismatch($sformatf("yaw_centi_deg expected %0d got %0d",
                                                  want.heading, m_yaw_centi_deg));
                    if (m_indicator_led !== want.led)
                        report_mismatch($sformatf("indicator_led expected %0d got %0d",
                                                  want.led, m_indicator_led));
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                recv_hold = LONG_HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                recv_hold = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_THRESHOLD)
            threshold_model = data[4:0];
    endtask

    // read back the threshold and compare with the model copy
    task automatic check_threshold();
        logic [31:0] got;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_THRESHOLD;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        got = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(threshold_model))
            report_mismatch($sformatf("threshold readback expected %0d got %0d",
                                      threshold_model, got));
    endtask

    function automatic void offer_byte(input logic [7:0] b);
        serial_bytes_pending.push_back(b);
        bytes_queued++;
    endfunction

    // sync pair plus payload, check byte right or deliberately wrong
    task automatic queue_frame(input logic [15:0] yaw, input bit good);
        logic [7:0] body [PAYLOAD_BYTES];
        logic [7:0] sum;
        int i;
        sum = '0;
        for (i = 0; i < PAYLOAD_BYTES - 1; i++)
            body[i] = 8'($urandom);
        body[1] = yaw[7:0];
        body[2] = yaw[15:8];
        for (i = 0; i < PAYLOAD_BYTES - 1; i++)
            sum = sum + body[i];
        body[PAYLOAD_BYTES - 1] = good ? sum : sum ^ 8'($urandom_range(1, 255));
        offer_byte(SYNC_FIRST);
        offer_byte(SYNC_SECOND);
        for (i = 0; i < PAYLOAD_BYTES; i++)
            offer_byte(body[i]);
    endtask

    function automatic logic [15:0] pick_yaw();
        case ($urandom_range(0, 15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'hB9B0;
            default: return 16'($urandom);
        endcase
    endfunction

    // line noise and broken sync sequences between frames
    task automatic queue_noise();
        int n;
        int k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: begin
                    offer_byte(SYNC_FIRST);
                    offer_byte(8'($urandom_range(1, 255)));
                end
                1: begin
                    offer_byte(SYNC_FIRST);
                    offer_byte(SYNC_FIRST);
                end
                2: begin
                    // header with a cut payload, swallows what follows
                    offer_byte(SYNC_FIRST);
                    offer_byte(SYNC_SECOND);
                    repeat ($urandom_range(1, 6)) offer_byte(8'($urandom));
                end
                default: offer_byte(8'($urandom));
            endcase
        end
    endtask

    // sender pause: everything sent and every report back
    task automatic wait_for_drain();
        do
            @(negedge aclk);
        while (serial_bytes_pending.size() != 0 || s_valid
               || frame_reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // stimulus sequence
    initial begin
        int ph;
        int phase_start;
        int thr;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // reset value, then a write outside the register map
        check_threshold();
        apb_write(ADDR_SPARE, 32'd0);
        check_threshold();

        // directed: failed confirm on a second sync byte, extreme yaws, bad sum
        offer_byte(SYNC_FIRST);
        offer_byte(SYNC_FIRST);
        offer_byte(SYNC_SECOND);
        queue_frame(16'h7FFF, 1'b1);
        queue_frame(16'h8000, 1'b0);
        wait_for_drain();

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                thr = PHASE_THRESHOLD[ph];
                if (thr < 0)
                    thr = $urandom_range(0, 31);
                apb_write(ADDR_THRESHOLD, {27'($urandom), 5'(thr)});
                check_threshold();
            end
            if (ph == PHASES - 1)
                idling_on = 1'b0;
            if (ph == 2)
                long_hold_req = 1'b1;
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 3) == 0)
                    queue_noise();
                queue_frame(pick_yaw(), $urandom_range(0, 3) != 0);
            end
            wait_for_drain();
        end

        $display("sent %0d bytes, checked %0d reports (%0d good, %0d bad checksum)",
                 bytes_accepted, reports_checked, good_frames, bad_frames);
        $display("indicator toggled %0d times, %0d input stall cycles, thresholds 0 to 31",
                 led_toggles, input_stall_cycles);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
